[rtl/core/vbfe_pkg.sv]
// ----------------------------------------------------------------------------
// vbfe_pkg
// Codes, operand types and the per-basis formula table for the lowest-order
// edge and face vector basis evaluator.
// ----------------------------------------------------------------------------
package vbfe_pkg;

  localparam logic [2:0] CELL_HEX   = 3'd0;
  localparam logic [2:0] CELL_QUAD  = 3'd1;
  localparam logic [2:0] CELL_TET   = 3'd2;
  localparam logic [2:0] CELL_TRI   = 3'd3;
  localparam logic [2:0] CELL_WEDGE = 3'd4;

  localparam logic SPACE_CURL = 1'b0;
  localparam logic SPACE_DIV  = 1'b1;

  // coordinate terms; P is one plus the coordinate, M is one minus it
  typedef enum logic [3:0] {
    T_ZERO, T_X, T_Y, T_Z, T_PX, T_PY, T_PZ, T_MX, T_MY, T_MZ
  } term_t;

  // how a component is formed from its two operands
  typedef enum logic [2:0] {
    M_ZERO,   // component unused
    M_LIN1,   // a + b
    M_LIN2,   // 2 (a + b)
    M_HALF,   // (a + b) / 2, rounded
    M_PROD0,  // a b, rounded
    M_PROD2   // a b / 4, rounded
  } mode_t;

  typedef struct packed {
    logic  neg;
    term_t term;
  } operand_t;

  typedef struct packed {
    mode_t    mode;
    operand_t a;
    operand_t b;
  } comp_t;

  typedef struct packed {
    comp_t cx;
    comp_t cy;
    comp_t cz;
  } basis_t;

  localparam operand_t OP_ZERO = {1'b0, T_ZERO};
  localparam operand_t OP_X    = {1'b0, T_X};
  localparam operand_t OP_Y    = {1'b0, T_Y};
  localparam operand_t OP_Z    = {1'b0, T_Z};
  localparam operand_t OP_NY   = {1'b1, T_Y};
  localparam operand_t OP_NZ   = {1'b1, T_Z};
  localparam operand_t OP_PX   = {1'b0, T_PX};
  localparam operand_t OP_PY   = {1'b0, T_PY};
  localparam operand_t OP_PZ   = {1'b0, T_PZ};
  localparam operand_t OP_NPY  = {1'b1, T_PY};
  localparam operand_t OP_MX   = {1'b0, T_MX};
  localparam operand_t OP_MY   = {1'b0, T_MY};
  localparam operand_t OP_MZ   = {1'b0, T_MZ};
  localparam operand_t OP_NMX  = {1'b1, T_MX};
  localparam operand_t OP_NMY  = {1'b1, T_MY};
  localparam operand_t OP_NMZ  = {1'b1, T_MZ};

  localparam comp_t C_ZERO = {M_ZERO, OP_ZERO, OP_ZERO};

  function automatic comp_t lin1(operand_t a, operand_t b);
    return {M_LIN1, a, b};
  endfunction

  function automatic comp_t lin2(operand_t a, operand_t b);
    return {M_LIN2, a, b};
  endfunction

  function automatic comp_t halve(operand_t a);
    return {M_HALF, a, OP_ZERO};
  endfunction

  function automatic comp_t prod0(operand_t a, operand_t b);
    return {M_PROD0, a, b};
  endfunction

  function automatic comp_t prod2(operand_t a, operand_t b);
    return {M_PROD2, a, b};
  endfunction

  // number of basis functions, zero for an unknown cell
  function automatic logic [3:0] basis_count(logic [2:0] kind, logic space);
    logic [3:0] n;
    case (kind)
      CELL_HEX:   n = (space == SPACE_DIV) ? 4'd6 : 4'd12;
      CELL_QUAD:  n = 4'd4;
      CELL_TET:   n = (space == SPACE_DIV) ? 4'd4 : 4'd6;
      CELL_TRI:   n = 4'd3;
      CELL_WEDGE: n = (space == SPACE_DIV) ? 4'd5 : 4'd9;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic basis_t basis_decode(logic [2:0] kind, logic space, logic [3:0] idx);
    basis_t r;
    r.cx = C_ZERO;
    r.cy = C_ZERO;
    r.cz = C_ZERO;
    case (kind)
      CELL_HEX: begin
        if (space == SPACE_CURL) begin
          case (idx)
            4'd0:    r.cx = prod2(OP_MY, OP_MZ);
            4'd1:    r.cy = prod2(OP_PX, OP_MZ);
            4'd2:    r.cx = prod2(OP_NPY, OP_MZ);
            4'd3:    r.cy = prod2(OP_NMX, OP_MZ);
            4'd4:    r.cx = prod2(OP_MY, OP_PZ);
            4'd5:    r.cy = prod2(OP_PX, OP_PZ);
            4'd6:    r.cx = prod2(OP_NPY, OP_PZ);
            4'd7:    r.cy = prod2(OP_NMX, OP_PZ);
            4'd8:    r.cz = prod2(OP_MX, OP_MY);
            4'd9:    r.cz = prod2(OP_PX, OP_MY);
            4'd10:   r.cz = prod2(OP_PX, OP_PY);
            4'd11:   r.cz = prod2(OP_MX, OP_PY);
            default: r.cx = C_ZERO;
          endcase
        end else begin
          case (idx)
            4'd0:    r.cy = halve(OP_NMY);
            4'd1:    r.cx = halve(OP_PX);
            4'd2:    r.cy = halve(OP_PY);
            4'd3:    r.cx = halve(OP_NMX);
            4'd4:    r.cz = halve(OP_NMZ);
            4'd5:    r.cz = halve(OP_PZ);
            default: r.cx = C_ZERO;
          endcase
        end
      end
      CELL_QUAD: begin
        if (space == SPACE_CURL) begin
          case (idx)
            4'd0:    r.cx = halve(OP_MY);
            4'd1:    r.cy = halve(OP_PX);
            4'd2:    r.cx = halve(OP_NPY);
            4'd3:    r.cy = halve(OP_NMX);
            default: r.cx = C_ZERO;
          endcase
        end else begin
          case (idx)
            4'd0:    r.cy = halve(OP_NMY);
            4'd1:    r.cx = halve(OP_PX);
            4'd2:    r.cy = halve(OP_PY);
            4'd3:    r.cx = halve(OP_NMX);
            default: r.cx = C_ZERO;
          endcase
        end
      end
      CELL_TET: begin
        if (space == SPACE_CURL) begin
          case (idx)
            4'd0: begin
              r.cx = lin2(OP_MY, OP_NZ);
              r.cy = lin2(OP_X, OP_ZERO);
              r.cz = lin2(OP_X, OP_ZERO);
            end
            4'd1: begin
              r.cx = lin2(OP_NY, OP_ZERO);
              r.cy = lin2(OP_X, OP_ZERO);
            end
            4'd2: begin
              r.cx = lin2(OP_NY, OP_ZERO);
              r.cy = lin2(OP_NMX, OP_Z);
              r.cz = lin2(OP_NY, OP_ZERO);
            end
            4'd3: begin
              r.cx = lin2(OP_Z, OP_ZERO);
              r.cy = lin2(OP_Z, OP_ZERO);
              r.cz = lin2(OP_MX, OP_NY);
            end
            4'd4: begin
              r.cx = lin2(OP_NZ, OP_ZERO);
              r.cz = lin2(OP_X, OP_ZERO);
            end
            4'd5: begin
              r.cy = lin2(OP_NZ, OP_ZERO);
              r.cz = lin2(OP_Y, OP_ZERO);
            end
            default: r.cx = C_ZERO;
          endcase
        end else begin
          r.cx = lin1((idx == 4'd2) ? OP_NMX : OP_X, OP_ZERO);
          r.cy = lin1((idx == 4'd0) ? OP_NMY : OP_Y, OP_ZERO);
          r.cz = lin1((idx == 4'd3) ? OP_NMZ : OP_Z, OP_ZERO);
        end
      end
      CELL_TRI: begin
        if (space == SPACE_CURL) begin
          case (idx)
            4'd0: begin
              r.cx = lin2(OP_MY, OP_ZERO);
              r.cy = lin2(OP_X, OP_ZERO);
            end
            4'd1: begin
              r.cx = lin2(OP_NY, OP_ZERO);
              r.cy = lin2(OP_X, OP_ZERO);
            end
            4'd2: begin
              r.cx = lin2(OP_NY, OP_ZERO);
              r.cy = lin2(OP_NMX, OP_ZERO);
            end
            default: r.cx = C_ZERO;
          endcase
        end else begin
          case (idx)
            4'd0: begin
              r.cx = lin2(OP_X, OP_ZERO);
              r.cy = lin2(OP_NMY, OP_ZERO);
            end
            4'd1: begin
              r.cx = lin2(OP_X, OP_ZERO);
              r.cy = lin2(OP_Y, OP_ZERO);
            end
            4'd2: begin
              r.cx = lin2(OP_NMX, OP_ZERO);
              r.cy = lin2(OP_Y, OP_ZERO);
            end
            default: r.cx = C_ZERO;
          endcase
        end
      end
      CELL_WEDGE: begin
        if (space == SPACE_CURL) begin
          case (idx)
            4'd0: begin
              r.cx = prod0(OP_MZ, OP_MY);
              r.cy = prod0(OP_X, OP_MZ);
            end
            4'd1: begin
              r.cx = prod0(OP_Y, OP_NMZ);
              r.cy = prod0(OP_X, OP_MZ);
            end
            4'd2: begin
              r.cx = prod0(OP_Y, OP_NMZ);
              r.cy = prod0(OP_MX, OP_NMZ);
            end
            4'd3: begin
              r.cx = prod0(OP_MY, OP_PZ);
              r.cy = prod0(OP_X, OP_PZ);
            end
            4'd4: begin
              r.cx = prod0(OP_NY, OP_PZ);
              r.cy = prod0(OP_X, OP_PZ);
            end
            4'd5: begin
              r.cx = prod0(OP_NY, OP_PZ);
              r.cy = prod0(OP_NMX, OP_PZ);
            end
            4'd6:    r.cz = lin1(OP_MX, OP_NY);
            4'd7:    r.cz = lin1(OP_X, OP_ZERO);
            4'd8:    r.cz = lin1(OP_Y, OP_ZERO);
            default: r.cx = C_ZERO;
          endcase
        end else begin
          case (idx)
            4'd0: begin
              r.cx = lin2(OP_X, OP_ZERO);
              r.cy = lin2(OP_NMY, OP_ZERO);
            end
            4'd1: begin
              r.cx = lin2(OP_X, OP_ZERO);
              r.cy = lin2(OP_Y, OP_ZERO);
            end
            4'd2: begin
              r.cx = lin2(OP_NMX, OP_ZERO);
              r.cy = lin2(OP_Y, OP_ZERO);
            end
            4'd3:    r.cz = halve(OP_NMZ);
            4'd4:    r.cz = halve(OP_PZ);
            default: r.cx = C_ZERO;
          endcase
        end
      end
      default: r.cx = C_ZERO;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/vector_basis_function_eval_top.sv]
// ----------------------------------------------------------------------------
// vector_basis_function_eval_top
// Evaluates the lowest-order edge (curl) or face (div) vector basis of a cell
// at one reference point and streams one word per basis function.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                            tuser                  tlast
//  s_*       in   point_x, point_y, point_z        cell_kind, space       -
//  m_*       out  value_x, value_y, value_z        basis_index            last_basis
//
// a point of n basis functions gives n result words, one per cycle while the output
// is not stalled, through the output register; a hexahedron edge point gives 12 words
// first result word is registered from the captured point once the output can take it
// the next point is taken in the cycle the last result of the current one
// enters the output register; an unknown cell kind is taken and gives no output
// reset clears the hold and output valid flags; a stalled output holds its word
module vector_basis_function_eval_top #(
  parameter int FRACTION_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point_x, point_y, point_z, zero pad
  input  logic [3:0]  s_tuser,   // cell_kind, space
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value_x, value_y, value_z
  output logic [3:0]  m_tuser,   // basis_index
  output logic        m_tlast
);
  import vbfe_pkg::*;

  localparam int CW = (FRACTION_BITS > 14) ? FRACTION_BITS : 14;
  localparam int TW = CW + 2;        // one plus or minus a coordinate
  localparam int W  = 2 * TW + 2;    // product and rounding headroom

  localparam logic signed [TW-1:0] ONE  = TW'(1) << FRACTION_BITS;
  localparam logic signed [W-1:0]  RND0 = W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [W-1:0]  RND2 = W'(1) << (FRACTION_BITS + 1);

  logic               hold_valid;
  logic [3:0]         idx;
  logic [3:0]         last_idx;
  logic [2:0]         kind;
  logic               space;
  logic signed [14:0] px;
  logic signed [14:0] py;
  logic signed [14:0] pz;

  logic       step;
  logic       step_last;
  logic       s_fire;
  logic [3:0] in_count;
  basis_t     basis;
  logic [15:0] vx;
  logic [15:0] vy;
  logic [15:0] vz;

  function automatic logic signed [TW-1:0] opval(operand_t op, logic signed [TW-1:0] ex,
                                                  logic signed [TW-1:0] ey,
                                                  logic signed [TW-1:0] ez);
    logic signed [TW-1:0] t;
    case (op.term)
      T_X:     t = ex;
      T_Y:     t = ey;
      T_Z:     t = ez;
      T_PX:    t = ONE + ex;
      T_PY:    t = ONE + ey;
      T_PZ:    t = ONE + ez;
      T_MX:    t = ONE - ex;
      T_MY:    t = ONE - ey;
      T_MZ:    t = ONE - ez;
      default: t = '0;
    endcase
    return op.neg ? -t : t;
  endfunction

  function automatic logic [15:0] sat16(logic signed [W-1:0] v);
    logic [15:0] r;
    if (v[W-1:15] == {(W-15){v[15]}}) begin
      r = v[15:0];
    end else begin
      r = v[W-1] ? 16'h8000 : 16'h7fff;
    end
    return r;
  endfunction

  function automatic logic [15:0] eval_comp(comp_t c, logic signed [TW-1:0] ex,
                                            logic signed [TW-1:0] ey,
                                            logic signed [TW-1:0] ez);
    logic signed [TW-1:0]   a;
    logic signed [TW-1:0]   b;
    logic signed [W-1:0]    sum;
    logic signed [2*TW-1:0] p;
    logic signed [W-1:0]    v;
    a   = opval(c.a, ex, ey, ez);
    b   = opval(c.b, ex, ey, ez);
    sum = W'(a) + W'(b);
    p   = a * b;
    case (c.mode)
      M_LIN1:  v = sum;
      M_LIN2:  v = sum <<< 1;
      M_HALF:  v = (sum + W'(1)) >>> 1;
      M_PROD0: v = (W'(p) + RND0) >>> FRACTION_BITS;
      M_PROD2: v = (W'(p) + RND2) >>> (FRACTION_BITS + 2);
      default: v = '0;
    endcase
    return sat16(v);
  endfunction

  assign in_count  = basis_count(s_tuser[2:0], s_tuser[3]);
  assign step      = hold_valid && (!m_tvalid || m_tready);
  assign step_last = step && (idx == last_idx);
  assign s_tready  = !hold_valid || step_last;
  assign s_fire    = s_tvalid && s_tready;

  always_comb begin
    basis = basis_decode(kind, space, idx);
    vx    = eval_comp(basis.cx, TW'(px), TW'(py), TW'(pz));
    vy    = eval_comp(basis.cy, TW'(px), TW'(py), TW'(pz));
    vz    = eval_comp(basis.cz, TW'(px), TW'(py), TW'(pz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_fire) begin
        // unknown cell kinds are dropped here
        hold_valid <= (in_count != 4'd0);
        idx        <= '0;
      end else if (step) begin
        if (step_last) begin
          hold_valid <= 1'b0;
        end
        idx <= idx + 4'd1;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      kind     <= s_tuser[2:0];
      space    <= s_tuser[3];
      px       <= s_tdata[14:0];
      py       <= s_tdata[29:15];
      pz       <= s_tdata[44:30];
      last_idx <= in_count - 4'd1;
    end
    if (step) begin
      m_tdata <= {vz, vy, vx};
      m_tuser <= idx;
      m_tlast <= (idx == last_idx);
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (idx <= last_idx))
    else $error("basis index ran past the last basis function");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_tready && hold_valid) |-> step_last)
    else $error("new point taken while the current one is unfinished");

  a_start_fresh: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (in_count != 4'd0)) |=> (hold_valid && (idx == 4'd0)))
    else $error("accepted point did not start at the first basis function");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    (step && !step_last) |=> hold_valid)
    else $error("point dropped before its last basis function");
`endif

endmodule
